FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W           = 32;
    localparam int COUNT_OUT_W      = 5;

    typedef logic signed [WORD_W-1:0] word_t;

    // Request codes on req_type.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_SPARE  = 2'd3
    } req_t;

    // Status codes on the status port.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What every cell of the chain does in a cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // One stored entry.
    typedef struct packed {
        logic  valid;
        word_t data;
        word_t prio;
    } entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t op;
        word_t    new_data;
        word_t    new_prio;
    } cell_ctrl_t;

    localparam word_t NONE_WORD = -32'sd1;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     left_entry,
    input  logic                left_take,
    input  spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t     entry,
    output logic                take
);

    logic              valid_reg;
    logic              valid_next;
    spq_pkg::word_t    data_reg;
    spq_pkg::word_t    data_next;
    spq_pkg::word_t    prio_reg;
    spq_pkg::word_t    prio_next;

    // The new item belongs at or before this slot when the slot is free or
    // the item outranks the stored one; equal priorities stay ahead.
    assign take = !valid_reg || (ctrl.new_prio > prio_reg);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        case (ctrl.op)
            spq_pkg::OP_INSERT:
            begin
                if (take)
                begin
                    if (left_take)
                    begin
                        valid_next = left_entry.valid;
                        data_next  = left_entry.data;
                        prio_next  = left_entry.prio;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        data_next  = ctrl.new_data;
                        prio_next  = ctrl.new_prio;
                    end
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                valid_next = right_entry.valid;
                data_next  = right_entry.data;
                prio_next  = right_entry.prio;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;
    assign entry.prio  = prio_reg;

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: request decode, cell chain and result port.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                            Handshake
// request   in         req_type, item_value, item_priority              start, busy
// result    out        head_value, head_priority, is_empty,             done
//                      entry_count, status
//
// A request is taken at every clock edge where start is high; busy stays low,
// since every cell settles a request at that edge. The result appears on
// the result ports in the next cycle, marked by done for exactly that cycle, so
// the sustained rate is one request per cycle.
// Reset empties the queue by clearing the valid bit of every cell; the stored
// data needs no clearing. The receiver cannot stall the result port.

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            req_type,
    input  logic signed [spq_pkg::WORD_W-1:0]     item_value,
    input  logic signed [spq_pkg::WORD_W-1:0]     item_priority,
    output logic                                  done,
    output logic signed [spq_pkg::WORD_W-1:0]     head_value,
    output logic signed [spq_pkg::WORD_W-1:0]     head_priority,
    output logic                                  is_empty,
    output logic [spq_pkg::COUNT_OUT_W-1:0]       entry_count,
    output logic [1:0]                            status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::cell_ctrl_t  ctrl;
    spq_pkg::entry_t      cell_entry [CAPACITY];
    logic [CAPACITY-1:0]  cell_take;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    logic                 done_next;
    spq_pkg::status_t     status_reg;
    spq_pkg::status_t     status_next;

    logic                 is_full;
    logic                 is_zero;

    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign is_zero = (count_reg == '0);

    // Decode the request into one operation broadcast to the whole chain.
    // A full queue drops an insert and an empty queue ignores a remove.
    always_comb
    begin
        ctrl.op       = spq_pkg::OP_HOLD;
        ctrl.new_data = item_value;
        ctrl.new_prio = item_priority;
        count_next    = count_reg;
        status_next   = spq_pkg::ST_OK;
        done_next     = start;
        if (start)
        begin
            case (spq_pkg::req_t'(req_type))
                spq_pkg::REQ_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.op    = spq_pkg::OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                spq_pkg::REQ_REMOVE:
                begin
                    if (is_zero)
                    begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op    = spq_pkg::OP_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    // Query and the unused code leave the queue as it is.
                    status_next = spq_pkg::ST_OK;
                end
            endcase
        end
    end

    // The chain of cells. Slot 0 is the head; an insert pushes entries toward
    // the tail and a remove pulls them toward the head, each cell trading only
    // with its direct neighbors.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;
            logic            left_take;

            if (g == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_take  = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_entry = cell_entry[g-1];
                assign left_take  = cell_take[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner_right
                assign right_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_take   (left_take),
                .right_entry (right_entry),
                .entry       (cell_entry[g]),
                .take        (cell_take[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= spq_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // The result shows the state the request left behind, which the cells and
    // the count hold during the cycle after it was taken.
    assign busy          = 1'b0;
    assign done          = done_reg;
    assign is_empty      = is_zero;
    assign head_value    = is_zero ? spq_pkg::NONE_WORD : cell_entry[0].data;
    assign head_priority = is_zero ? spq_pkg::NONE_WORD : cell_entry[0].prio;
    assign entry_count   = spq_pkg::COUNT_OUT_W'(count_reg);
    assign status        = status_reg;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the sorted priority queue: directed and random requests.
`timescale 1ns / 1ps

// The testbench drives requests on the command port (start, busy) and checks
// every result strobed by done against its own model of the queue. The model
// sits in a small scoreboard class. It keeps a sorted copy of the entries,
// computes the expected head, count and status for each accepted request, and
// queues that report. Each strobed result is compared field by field with the
// oldest queued report.
//
// The stimulus starts with a directed run: requests on an empty queue, a fill
// with extreme and tied priorities, an insert on a full queue, and then a query,
// the spare code and removals. A random run follows. It moves through fill,
// drain and balanced spells, so the queue keeps swinging between empty and
// full. Most priorities come from a narrow band so that ties are common.

module tb;

    localparam int CAPACITY        = spq_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int SPELL_LENGTH    = 60;
    // The slowest correct run is about 1530 requests, each followed by a random
    // gap; the limit leaves ample room.
    localparam int CYCLE_LIMIT     = 400000;
    // A result follows its request in the next cycle. Spare cycles at the
    // end let any stray strobe show up.
    localparam int TAIL_CYCLES     = 4;

    // Shape of the random run.
    typedef enum int {
        SPELL_FILL,
        SPELL_DRAIN,
        SPELL_MIXED
    } spell_t;

    // One result as it appears on the result ports.
    typedef struct {
        spq_pkg::word_t head_value;
        spq_pkg::word_t head_priority;
        logic           is_empty;
        logic [4:0]     entry_count;
        logic [1:0]     status;
    } queue_report_t;

    // The scoreboard holds a sorted model of the queue and the reports still
    // waiting for their result strobe.
    class queue_scoreboard;
        spq_pkg::word_t slot_value[CAPACITY];
        spq_pkg::word_t slot_priority[CAPACITY];
        int             held;
        queue_report_t  pending_reports[$];
        int             mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        // Applies an accepted request to the model and queues the report it causes.
        function void note_request(logic [1:0] req, spq_pkg::word_t value,
                                   spq_pkg::word_t prio);
            queue_report_t expected;
            int            pos;
            expected.status = spq_pkg::ST_OK;
            if (req == spq_pkg::REQ_INSERT) begin
                if (held >= CAPACITY) begin
                    expected.status = spq_pkg::ST_FULL;
                end
                else begin
                    // A new entry goes behind every entry of greater or equal priority.
                    pos = 0;
                    while (pos < held && !(prio > slot_priority[pos]))
                        pos++;
                    for (int i = held; i > pos; i--)
                    begin
                        slot_value[i] = slot_value[i-1];
                        slot_priority[i] = slot_priority[i-1];
                    end
                    slot_value[pos] = value;
                    slot_priority[pos] = prio;
                    held++;
                end
            end
            else if (req == spq_pkg::REQ_REMOVE) begin
                if (held == 0) begin
                    expected.status = spq_pkg::ST_EMPTY;
                end
                else begin
                    for (int i = 0; i + 1 < held; i++)
                    begin
                        slot_value[i] = slot_value[i+1];
                        slot_priority[i] = slot_priority[i+1];
                    end
                    held--;
                end
            end
            // A query and the spare code leave the queue as it is.
            if (held == 0) begin
                expected.head_value = spq_pkg::NONE_WORD;
                expected.head_priority = spq_pkg::NONE_WORD;
                expected.is_empty = 1'b1;
            end
            else begin
                expected.head_value = slot_value[0];
                expected.head_priority = slot_priority[0];
                expected.is_empty = 1'b0;
            end
            expected.entry_count = 5'(held);
            pending_reports.push_back(expected);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // Compares a strobed result with the oldest queued report.
        task check_result(queue_report_t got);
            queue_report_t expected;
            if (pending_reports.size() == 0) begin
                report($sformatf("result with no request waiting, head_value %0d",
                                 got.head_value));
                return;
            end
            expected = pending_reports.pop_front();
            if (got.head_value !== expected.head_value)
                report($sformatf("head_value %0d, expected %0d",
                                 got.head_value, expected.head_value));
            if (got.head_priority !== expected.head_priority)
                report($sformatf("head_priority %0d, expected %0d",
                                 got.head_priority, expected.head_priority));
            if (got.is_empty !== expected.is_empty)
                report($sformatf("is_empty %0b, expected %0b",
                                 got.is_empty, expected.is_empty));
            if (got.entry_count !== expected.entry_count)
                report($sformatf("entry_count %0d, expected %0d",
                                 got.entry_count, expected.entry_count));
            if (got.status !== expected.status)
                report($sformatf("status %0d, expected %0d",
                                 got.status, expected.status));
        endtask

        function int waiting();
            return pending_reports.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic [1:0]     req_type = spq_pkg::REQ_QUERY;
    spq_pkg::word_t item_value = '0;
    spq_pkg::word_t item_priority = '0;
    logic           done;
    spq_pkg::word_t head_value;
    spq_pkg::word_t head_priority;
    logic           is_empty;
    logic [4:0]     entry_count;
    logic [1:0]     status;

    queue_scoreboard sb;
    int              cycle_count = 0;
    spell_t          spell = SPELL_MIXED;
    logic            burst = 1'b0;

    sorted_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .item_value(item_value),
        .item_priority(item_priority),
        .done(done),
        .head_value(head_value),
        .head_priority(head_priority),
        .is_empty(is_empty),
        .entry_count(entry_count),
        .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sampling at the rising edge sees the values that the edge itself
    // captures, because every input and output changes through nonblocking
    // assignments. The result is checked before the request of the same edge
    // is noted; both orders work, since the report queue is first-in first-out.
    always @(posedge clk)
    begin : monitor
        queue_report_t got;
        if (rst_n) begin
            if (done) begin
                got.head_value = head_value;
                got.head_priority = head_priority;
                got.is_empty = is_empty;
                got.entry_count = entry_count;
                got.status = status;
                sb.check_result(got);
            end
            if (start && !busy)
                sb.note_request(req_type, item_value, item_priority);
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drives one request and holds it until an edge with busy low takes it.
    task send_request(logic [1:0] req, spq_pkg::word_t value, spq_pkg::word_t prio);
        start <= 1'b1;
        req_type <= req;
        item_value <= value;
        item_priority <= prio;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Idles the request port for a random gap. Most gaps are short and a few
    // are long. During a burst spell no gap is left at all. The fields carry
    // noise while start is low.
    task pause_requests();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (burst || roll < 50)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            start <= 1'b0;
            req_type <= 2'($urandom);
            item_value <= spq_pkg::word_t'($urandom);
            item_priority <= spq_pkg::word_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Priorities for the directed fill: both extremes, zero, minus one, and
    // several ties, so that arrival order among equal priorities shows.
    function automatic spq_pkg::word_t fill_priority(int idx);
        case (idx)
            0, 7:         return 32'sh7fffffff;
            1, 8:         return 32'sh80000000;
            2, 14:        return 32'sd0;
            3:            return -32'sd1;
            4, 5, 6, 11:  return 32'sd5;
            9:            return 32'sd1;
            10:           return -32'sd2;
            12:           return 32'sd100;
            13:           return -32'sd100;
            default:      return 32'sh7ffffffe;
        endcase
    endfunction

    function automatic spq_pkg::word_t fill_value(int idx);
        case (idx)
            0:        return 32'sh7fffffff;
            1:        return 32'sh80000000;
            // An entry of value and priority minus one looks like the empty
            // marker, yet is_empty must stay low.
            3:        return -32'sd1;
            default:  return spq_pkg::word_t'(32'h1000 + idx);
        endcase
    endfunction

    // Random priorities lean on a narrow band around zero to force many ties.
    function automatic spq_pkg::word_t random_priority();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return spq_pkg::word_t'($urandom_range(0, 7)) - 32'sd4;
        else if (roll == 6)
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        else
            return spq_pkg::word_t'($urandom);
    endfunction

    // Picks a request code to suit the current spell.
    function automatic logic [1:0] random_request();
        int roll;
        int insert_share;
        int remove_share;
        roll = $urandom_range(0, 99);
        case (spell)
            SPELL_FILL:
            begin
                insert_share = 70;
                remove_share = 15;
            end
            SPELL_DRAIN:
            begin
                insert_share = 15;
                remove_share = 70;
            end
            default:
            begin
                insert_share = 45;
                remove_share = 40;
            end
        endcase
        if (roll < insert_share)
            return spq_pkg::REQ_INSERT;
        else if (roll < insert_share + remove_share)
            return spq_pkg::REQ_REMOVE;
        else if (roll < 95)
            return spq_pkg::REQ_QUERY;
        else
            return spq_pkg::REQ_SPARE;
    endfunction

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Requests on an empty queue: query, spare code and a remove that must
        // report an empty queue.
        send_request(spq_pkg::REQ_QUERY, 32'sd0, 32'sd0);
        pause_requests();
        send_request(spq_pkg::REQ_SPARE, -32'sd1, -32'sd1);
        pause_requests();
        send_request(spq_pkg::REQ_REMOVE, 32'sh7fffffff, 32'sh7fffffff);
        pause_requests();

        // Fill the queue to capacity with extreme and tied priorities.
        for (int i = 0; i < CAPACITY; i++)
        begin
            send_request(spq_pkg::REQ_INSERT, fill_value(i), fill_priority(i));
            pause_requests();
        end

        // An insert on a full queue is dropped, even with the top priority.
        send_request(spq_pkg::REQ_INSERT, 32'sh55aa55aa, 32'sh7fffffff);
        pause_requests();
        send_request(spq_pkg::REQ_QUERY, 32'sh80000000, 32'sh80000000);
        pause_requests();
        send_request(spq_pkg::REQ_SPARE, 32'sd0, 32'sd0);
        pause_requests();
        send_request(spq_pkg::REQ_REMOVE, 32'sd0, 32'sd0);
        pause_requests();
        send_request(spq_pkg::REQ_REMOVE, 32'sd0, 32'sd0);
        pause_requests();

        // Random run in spells, so the queue keeps swinging between its ends.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % SPELL_LENGTH == 0) begin
                spell = spell_t'($urandom_range(0, 2));
                burst = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request(), spq_pkg::word_t'($urandom), random_priority());
            pause_requests();
        end

        start <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sorted_priority_queue_top.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/sv/tb.sv
